FILE: rtl/bmf_pkg.sv
// Shared types, constants and arithmetic helpers of the biased MF SGD engine.
`default_nettype none
package bmf_pkg;

  localparam int MAX_FACTORS   = 32;
  localparam int MAX_USERS     = 4096;
  localparam int MAX_ITEMS     = 4096;
  localparam int FRACTION_BITS = 16;
  localparam int RATE_BITS     = 16;
  localparam int VALUE_BITS    = 24;
  localparam int BIAS_SLOT     = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam int K_W   = $clog2(MAX_FACTORS);
  localparam int U_W   = $clog2(MAX_USERS);
  localparam int I_W   = $clog2(MAX_ITEMS);
  localparam int QP_W  = $clog2(QUEUE_DEPTH);
  localparam int NF_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam int ONE_I = 1 << FRACTION_BITS;
  localparam value_t ONE_V  = VALUE_BITS'(ONE_I);
  localparam value_t HALF_V = VALUE_BITS'(ONE_I / 2);

  localparam logic signed [39:0] SAT_HI = 40'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

  localparam logic [24:0] SIG_T_TOP = 25'(5 * ONE_I);
  localparam logic [24:0] SIG_T_MID = 25'((19 * ONE_I) / 8);
  localparam logic [24:0] SIG_C_TOP = 25'((27 * ONE_I) / 32);
  localparam logic [24:0] SIG_C_MID = 25'((5 * ONE_I) / 8);
  localparam logic [24:0] SIG_C_LOW = 25'(ONE_I / 2);

  typedef enum logic [1:0] {
    CMD_TRAIN     = 2'd0,
    CMD_PREDICT   = 2'd1,
    CMD_LOAD_USER = 2'd2,
    CMD_LOAD_ITEM = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TASK_MODE   = 3'd0,
    REG_FACTORS     = 3'd1,
    REG_LEARN_RATE  = 3'd2,
    REG_REG_WEIGHT  = 3'd3,
    REG_GLOBAL_MEAN = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_SUM,
    ST_SIG,
    ST_ERR,
    ST_UPD
  } bmf_state_t;

  typedef enum logic [1:0] {
    EL_FACTOR,
    EL_USER_BIAS,
    EL_ITEM_BIAS
  } elem_t;

  typedef struct packed {
    cmd_t           cmd;
    logic           is_load;
    logic           train;
    logic           use_u;
    logic           use_i;
    logic           slot_bias;
    logic           slot_factor;
    logic [K_W-1:0] slot;
    logic [U_W-1:0] user;
    logic [I_W-1:0] item;
    value_t         rating;
    value_t         load_value;
  } bmf_op_t;

  function automatic value_t sat_value(input logic signed [39:0] v);
    value_t r;
    if (v > SAT_HI) r = SAT_HI[VALUE_BITS-1:0];
    else if (v < SAT_LO) r = SAT_LO[VALUE_BITS-1:0];
    else r = v[VALUE_BITS-1:0];
    return r;
  endfunction

  // Round to nearest, ties up, then drop the fraction bits.
  function automatic logic signed [32:0] round_48(input logic signed [47:0] x);
    logic signed [48:0] t;
    t = {x[47], x} + 49'(1 << (FRACTION_BITS - 1));
    return t[48:FRACTION_BITS];
  endfunction

  function automatic logic signed [25:0] round_41(input logic signed [40:0] x);
    logic signed [41:0] t;
    t = {x[40], x} + 42'(1 << (RATE_BITS - 1));
    return t[41:RATE_BITS];
  endfunction

  function automatic logic signed [35:0] round_51(input logic signed [50:0] x);
    logic signed [51:0] t;
    t = {x[50], x} + 52'(1 << (RATE_BITS - 1));
    return t[51:RATE_BITS];
  endfunction

  // Piecewise linear sigmoid, mirrored for negative input.
  function automatic value_t sigmoid(input value_t s);
    logic [24:0] ax;
    logic [24:0] y;
    ax = s[VALUE_BITS-1] ? (25'd0 - {s[VALUE_BITS-1], s}) : {1'b0, s};
    if (ax >= SIG_T_TOP) y = 25'(ONE_I);
    else if (ax >= SIG_T_MID) y = (ax >> 5) + SIG_C_TOP;
    else if (ax >= 25'(ONE_I)) y = (ax >> 3) + SIG_C_MID;
    else y = (ax >> 2) + SIG_C_LOW;
    if (s[VALUE_BITS-1]) y = 25'(ONE_I) - y;
    return y[VALUE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bmf_in_if.sv
// Input channel: command items with valid/ready handshake.
`default_nettype none
interface bmf_in_if;
  import bmf_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [11:0] user_index;
  logic [11:0] item_index;
  logic       user_known;
  logic       item_known;
  logic [5:0] factor_slot;
  value_t     rating;
  value_t     load_value;
  modport source(output valid, command, user_index, item_index, user_known, item_known,
                 factor_slot, rating, load_value, input ready);
  modport sink(input valid, command, user_index, item_index, user_known, item_known,
               factor_slot, rating, load_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/bmf_out_if.sv
// Result channel: prediction, error and class flag with valid/ready handshake.
`default_nettype none
interface bmf_out_if;
  import bmf_pkg::*;
  logic   valid;
  logic   ready;
  value_t prediction;
  value_t error;
  logic   wrong_class;
  modport source(output valid, prediction, error, wrong_class, input ready);
  modport sink(input valid, prediction, error, wrong_class, output ready);
endinterface
`default_nettype wire

FILE: rtl/bmf_front.sv
// Front end: accepts command items and decodes them into queue operations.
`default_nettype none
module bmf_front (
  bmf_in_if.sink           req,
  input  logic             full,
  output logic             push,
  output bmf_pkg::bmf_op_t op
);
  import bmf_pkg::*;

  cmd_t cmd;

  assign cmd       = cmd_t'(req.command);
  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    op             = '0;
    op.cmd         = cmd;
    op.is_load     = (cmd == CMD_LOAD_USER) || (cmd == CMD_LOAD_ITEM);
    op.train       = (cmd == CMD_TRAIN);
    // train always uses both sides; predict only the known ones
    op.use_u       = (cmd == CMD_TRAIN) || req.user_known;
    op.use_i       = (cmd == CMD_TRAIN) || req.item_known;
    op.slot_bias   = (req.factor_slot == 6'(BIAS_SLOT));
    op.slot_factor = ({1'b0, req.factor_slot} < 7'(MAX_FACTORS));
    op.slot        = req.factor_slot[K_W-1:0];
    op.user        = req.user_index[U_W-1:0];
    op.item        = req.item_index[I_W-1:0];
    op.rating      = req.rating;
    op.load_value  = req.load_value;
  end

endmodule
`default_nettype wire

FILE: rtl/bmf_queue.sv
// Short operation queue between front end and back end.
`default_nettype none
module bmf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bmf_pkg::bmf_op_t op_in,
  output logic             full,
  input  logic             pop,
  output logic             op_valid,
  output bmf_pkg::bmf_op_t op_out
);
  import bmf_pkg::*;

  bmf_op_t         entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  assign full     = (count == (QP_W + 1)'(QUEUE_DEPTH));
  assign op_valid = (count != '0);
  assign op_out   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= op_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bmf_back.sv
// Back end: factor and bias tables, dot-product and update passes, result register.
`default_nettype none
module bmf_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              op_valid,
  input  bmf_pkg::bmf_op_t                  op,
  output logic                              pop,
  bmf_out_if.source                         rsp
);
  import bmf_pkg::*;

  localparam int UF_AW = U_W + K_W;
  localparam int IF_AW = I_W + K_W;

  // configuration
  logic            mode;
  logic [NF_W-1:0] nf_cfg;
  logic [15:0]     lr;
  logic [15:0]     rw;
  value_t          gm;
  logic [NF_W-1:0] nf;
  logic [NF_W-1:0] nf2;

  // tables
  value_t umem  [MAX_USERS * MAX_FACTORS];
  value_t imem  [MAX_ITEMS * MAX_FACTORS];
  value_t ubmem [MAX_USERS];
  value_t ibmem [MAX_ITEMS];

  bmf_state_t      state;
  bmf_state_t      state_next;
  bmf_op_t         cur;
  logic [NF_W-1:0] cnt;
  logic            issue;
  elem_t           kind_a;

  value_t ufd, ifd, bu_r, bi_r;

  // pipeline
  logic           v_b, v_c, v_d;
  elem_t          kind_b, kind_c, kind_d;
  logic [K_W-1:0] k_b, k_c, k_d;
  value_t         p_b, q_b, p_c, q_c, p_d, q_d;
  logic signed [47:0] dp_c, m_eq, m_ep;
  logic signed [40:0] m_rp, m_rq;
  logic signed [33:0] gp, gq;
  logic signed [50:0] lp, lq;
  logic signed [16:0] rw_s, lr_s;
  value_t             newp, newq;

  logic signed [38:0] acc;
  value_t             s_r, pred_r, err_r, err_n;
  logic               wrong_n;

  logic            out_vld;
  value_t          pred_o, err_o;
  logic            wrong_o;

  logic                 uf_we, if_we, ub_we, ib_we, upd_wr;
  logic [UF_AW-1:0]     uf_waddr;
  logic [IF_AW-1:0]     if_waddr;
  logic [U_W-1:0]       ub_waddr;
  logic [I_W-1:0]       ib_waddr;
  value_t               uf_wdata, if_wdata, ub_wdata, ib_wdata;

  assign rw_s = $signed({1'b0, rw});
  assign lr_s = $signed({1'b0, lr});

  always_comb begin
    if (nf_cfg == '0) nf = NF_W'(1);
    else if ({1'b0, nf_cfg} > (NF_W + 1)'(MAX_FACTORS)) nf = NF_W'(MAX_FACTORS);
    else nf = nf_cfg;
  end
  assign nf2 = nf + NF_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b1;
      nf_cfg <= NF_W'(25);
      lr     <= 16'd655;
      rw     <= 16'd328;
      gm     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TASK_MODE:   mode   <= cfg_data[0];
        REG_FACTORS:     nf_cfg <= cfg_data[NF_W-1:0];
        REG_LEARN_RATE:  lr     <= cfg_data[15:0];
        REG_REG_WEIGHT:  rw     <= cfg_data[15:0];
        REG_GLOBAL_MEAN: gm     <= cfg_data[VALUE_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (op_valid && (!out_vld || rsp.ready)) begin
          pop = 1'b1;
          case (op.cmd)
            CMD_TRAIN:   state_next = ST_DOT;
            CMD_PREDICT: state_next = (op.use_u && op.use_i) ? ST_DOT : ST_SUM;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_DOT: begin
        issue = (cnt < nf);
        if (cnt == nf && !v_b && !v_c) state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_SIG;
      ST_SIG: state_next = ST_ERR;
      ST_ERR: state_next = cur.train ? ST_UPD : ST_IDLE;
      ST_UPD: begin
        issue = (cnt < nf2);
        if (cnt == nf2 && !v_b && !v_c && !v_d) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cnt < nf) kind_a = EL_FACTOR;
    else if (cnt == nf) kind_a = EL_USER_BIAS;
    else kind_a = EL_ITEM_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (pop || state == ST_ERR) cnt <= '0;
    else if (issue) cnt <= cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= op;
  end

  // table reads, registered
  always_ff @(posedge clk) begin
    if (issue && kind_a == EL_FACTOR) begin
      ufd <= umem[{cur.user, cnt[K_W-1:0]}];
      ifd <= imem[{cur.item, cnt[K_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bu_r <= ubmem[op.user];
      bi_r <= ibmem[op.item];
    end
  end

  // pipeline: b = read data, c = products, d = scaled gradients
  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_b <= issue;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  always_comb begin
    case (kind_b)
      EL_FACTOR: begin
        p_b = ufd;
        q_b = ifd;
      end
      EL_USER_BIAS: begin
        p_b = bu_r;
        q_b = ONE_V;
      end
      default: begin
        p_b = ONE_V;
        q_b = bi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_b <= kind_a;
    k_b    <= cnt[K_W-1:0];
    dp_c   <= p_b * q_b;
    m_eq   <= err_r * q_b;
    m_ep   <= err_r * p_b;
    m_rp   <= rw_s * p_b;
    m_rq   <= rw_s * q_b;
    p_c    <= p_b;
    q_c    <= q_b;
    kind_c <= kind_b;
    k_c    <= k_b;
    lp     <= lr_s * gp;
    lq     <= lr_s * gq;
    p_d    <= p_c;
    q_d    <= q_c;
    kind_d <= kind_c;
    k_d    <= k_c;
  end

  assign gp   = 34'(round_48(m_eq)) - 34'(round_41(m_rp));
  assign gq   = 34'(round_48(m_ep)) - 34'(round_41(m_rq));
  assign newp = sat_value(40'(p_d) + 40'(round_51(lp)));
  assign newq = sat_value(40'(q_d) + 40'(round_51(lq)));

  // prediction path
  always_ff @(posedge clk) begin
    if (pop) acc <= '0;
    else if (state == ST_DOT && v_c) acc <= acc + 39'(round_48(dp_c));
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM)
      s_r <= sat_value(40'(gm) + (cur.use_u ? 40'(bu_r) : 40'sd0)
                       + (cur.use_i ? 40'(bi_r) : 40'sd0) + 40'(acc));
    if (state == ST_SIG) pred_r <= mode ? sigmoid(s_r) : s_r;
    if (state == ST_ERR) err_r <= err_n;
  end

  always_comb begin
    value_t rt;
    rt      = cur.rating;
    err_n   = sat_value(40'(rt) - 40'(pred_r));
    wrong_n = mode && (((pred_r >= HALF_V) && (rt == '0)) ||
                       ((pred_r < HALF_V) && (rt == ONE_V)));
  end

  // table writes: loads at pop, updates at the end of the pipeline
  assign upd_wr = (state == ST_UPD) && v_d;

  always_comb begin
    uf_we    = (pop && op.cmd == CMD_LOAD_USER && op.slot_factor) ||
               (upd_wr && kind_d == EL_FACTOR);
    if_we    = (pop && op.cmd == CMD_LOAD_ITEM && op.slot_factor) ||
               (upd_wr && kind_d == EL_FACTOR);
    ub_we    = (pop && op.cmd == CMD_LOAD_USER && op.slot_bias) ||
               (upd_wr && kind_d == EL_USER_BIAS);
    ib_we    = (pop && op.cmd == CMD_LOAD_ITEM && op.slot_bias) ||
               (upd_wr && kind_d == EL_ITEM_BIAS);
    uf_waddr = upd_wr ? {cur.user, k_d} : {op.user, op.slot};
    if_waddr = upd_wr ? {cur.item, k_d} : {op.item, op.slot};
    ub_waddr = upd_wr ? cur.user : op.user;
    ib_waddr = upd_wr ? cur.item : op.item;
    uf_wdata = upd_wr ? newp : op.load_value;
    if_wdata = upd_wr ? newq : op.load_value;
    ub_wdata = upd_wr ? newp : op.load_value;
    ib_wdata = upd_wr ? newq : op.load_value;
  end

  always_ff @(posedge clk) begin
    if (uf_we) umem[uf_waddr] <= uf_wdata;
  end

  always_ff @(posedge clk) begin
    if (if_we) imem[if_waddr] <= if_wdata;
  end

  always_ff @(posedge clk) begin
    if (ub_we) ubmem[ub_waddr] <= ub_wdata;
  end

  always_ff @(posedge clk) begin
    if (ib_we) ibmem[ib_waddr] <= ib_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      if (rsp.ready) out_vld <= 1'b0;
      if ((pop && op.is_load) || state == ST_ERR) out_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op.is_load) begin
      pred_o  <= '0;
      err_o   <= '0;
      wrong_o <= 1'b0;
    end else if (state == ST_ERR) begin
      pred_o  <= pred_r;
      err_o   <= err_n;
      wrong_o <= wrong_n;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.prediction  = pred_o;
  assign rsp.error       = err_o;
  assign rsp.wrong_class = wrong_o;

endmodule
`default_nettype wire

FILE: rtl/biased_mf_sgd_engine.sv
// Biased matrix-factorisation SGD engine: front end, op queue and back end.
// A predict or train result is registered after the dot pass over the F factors in use
// (skipped for a predict without both indices known), sum, sigmoid and error steps; a
// load's zero result is registered at the edge that pops it. The back end works on one
// item at a time and pops the next only when idle with its result register free or being
// taken; a train item also runs an update pass over the F factors and two biases first.
// Reset clears control state and restores register defaults; tables hold garbage
// until loaded, with no clearing pass.
`default_nettype none
module biased_mf_sgd_engine (
  input  logic                           clk,
  input  logic                           rst,
  bmf_in_if.sink                         req,
  bmf_out_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmf_pkg::*;

  logic    push, full, pop, op_valid;
  bmf_op_t op_in, op_head;

  bmf_front u_front (
    .req  (req),
    .full (full),
    .push (push),
    .op   (op_in)
  );

  bmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .op_in    (op_in),
    .full     (full),
    .pop      (pop),
    .op_valid (op_valid),
    .op_out   (op_head)
  );

  bmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (op_valid),
    .op        (op_head),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
